### sv/lbt_pkg.sv
// Shared types and constants for the L2 order book price level table.
// No dependencies; imported by every module of the block.
package lbt_pkg;

    localparam int PRICE_W    = 24;
    localparam int QTY_W      = 32;
    localparam int SUM_W      = 38;
    localparam int MID_W      = 25;
    localparam int IMB_W      = 16;
    localparam int DEPTH_W    = 7;
    localparam int DIV_W      = SUM_W + 1;
    localparam int DEF_LEVELS = 64;
    localparam int ENTRY_W    = PRICE_W + QTY_W;

    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 232;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [DEPTH_W-1:0] DEPTH_RST = 7'd10;
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    localparam logic REG_DEPTH = 1'b0;   // paddr[2] register index
    localparam logic SIDE_BID  = 1'b0;
    localparam logic SIDE_ASK  = 1'b1;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_ACT,
        S_DEL_RD, S_DEL_WR, S_INS_RD, S_INS_WR,
        S_REP0, S_REP1, S_REP2, S_RB_RD, S_RB_CHK, S_RA_RD, S_RA_CHK,
        S_TB_RD, S_TA_RD, S_TA_CAP, S_SUM_RD, S_SUM_ACC,
        S_DIV, S_DIV_WAIT, S_OUT
    } state_t;

endpackage

### sv/lbt_mem.sv
// Level memory: one write port, one read port, registered read data.
// Depends on lbt_pkg.
module lbt_mem #(
    parameter int AW = 7
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [lbt_pkg::ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [lbt_pkg::ENTRY_W-1:0] rdata
);
    import lbt_pkg::*;

    logic [ENTRY_W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lbt_div.sv
// Serial divider for the imbalance ratio: floor(num * 2^15 / den), num <= den.
// One quotient bit per cycle. Depends on lbt_pkg.
module lbt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lbt_pkg::DIV_W-1:0] num,
    input  logic [lbt_pkg::DIV_W-1:0] den,
    output logic                      done,
    output logic [lbt_pkg::IMB_W-1:0] quo
);
    import lbt_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next, den_reg, den_next;
    logic [IMB_W-1:0] q_reg, q_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [DIV_W:0]   r2;
    logic             ge;

    always_comb
    begin
        r2        = {rem_reg, 1'b0};
        ge        = r2 >= {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next = den;
            rem_next = num;
            if (num == den)
            begin
                q_next    = IMB_W'(1) << (IMB_W - 1);
                done_next = 1'b1;
            end
            else
            begin
                q_next    = '0;
                cnt_next  = 4'(IMB_W - 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_W'(r2 - {1'b0, den_reg}) : DIV_W'(r2);
            q_next   = {q_reg[IMB_W-2:0], ge};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

### sv/l2_order_book_level_table.sv
// L2 order book price level table. Each side is a circular buffer in one shared level memory,
// best level at the side's head pointer, so the crossed repair only moves the head. One
// transaction at a time: a search walks the side one level at a time, an insert or removal
// shifts the tail one level at a time, the repair scans the removed levels, the depth sums
// read min(depth, count) levels per side, and the imbalance divide is bit-serial, with a
// shortcut when one side sums to zero, and is skipped when both do. All steps share the single
// memory read port. An item that finishes waits in the output state until the previous
// result has left.
// Depends on lbt_pkg, lbt_mem, lbt_div.
module l2_order_book_level_table #(
    parameter int LEVELS = lbt_pkg::DEF_LEVELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lbt_pkg::S_TDATA_W-1:0] s_tdata,  // price, quantity
    input  logic [lbt_pkg::S_TUSER_W-1:0] s_tuser,  // req_type, side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // top_bid, bid_valid, top_ask, ask_valid, spread, mid_doubled, bid_depth_volume,
    // ask_depth_volume, imbalance, level_volume, crossed_fixed, table_full
    output logic [lbt_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbt_pkg::PADDR_W-1:0]   paddr,
    input  logic [lbt_pkg::PDATA_W-1:0]   pwdata,
    output logic [lbt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import lbt_pkg::*;

    localparam int AW = $clog2(LEVELS);
    localparam int CW = $clog2(LEVELS + 1);

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] head, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(off);
        if (s >= (CW+1)'(LEVELS))
        begin
            s = s - (CW+1)'(LEVELS);
        end
        return s[AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [1:0]          rt_reg, rt_next;
    logic                sd_reg, sd_next, sm_reg, sm_next;
    logic [PRICE_W-1:0]  pr_reg, pr_next, ref_reg, ref_next, bb_reg, bb_next, ba_reg, ba_next;
    logic [QTY_W-1:0]    qt_reg, qt_next, fv_reg, fv_next, lvl_reg, lvl_next;
    logic [CW-1:0]       idx_reg, idx_next, pos_reg, pos_next;
    logic [CW-1:0]       bcnt_reg, bcnt_next, acnt_reg, acnt_next;
    logic [AW-1:0]       bhead_reg, bhead_next, ahead_reg, ahead_next;
    logic                found_reg, found_next, crossed_reg, crossed_next, full_reg, full_next;
    logic [SUM_W-1:0]    acc_reg, acc_next, bs_reg, bs_next, as_reg, as_next;
    logic [IMB_W-1:0]    imb_reg, imb_next;
    logic [DEPTH_W-1:0]  depth_reg;
    logic                mval_reg, mval_next;
    logic [M_TDATA_W-1:0] mdat_reg, mdat_next;

    logic               rd_side, wr_side, we;
    logic [CW-1:0]      rd_idx, wr_idx;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [AW:0]        raddr, waddr;
    logic [PRICE_W-1:0] rd_price;
    logic [QTY_W-1:0]   rd_vol;
    logic [CW-1:0]      cnt_sd, cnt_sm;
    logic               ranks_ahead, idx_lt_sum, out_free, div_start, div_done;
    logic [SUM_W:0]     acc_sum;
    logic [DIV_W-1:0]   tot, diff;
    logic [IMB_W-1:0]   quo;
    logic [SUM_W-1:0]   mid_full;

    assign rd_price    = rdata[PRICE_W-1:0];
    assign rd_vol      = rdata[ENTRY_W-1:PRICE_W];
    assign cnt_sd      = sd_reg ? acnt_reg : bcnt_reg;
    assign cnt_sm      = sm_reg ? acnt_reg : bcnt_reg;
    assign ranks_ahead = sd_reg ? (rd_price < pr_reg) : (rd_price > pr_reg);
    assign idx_lt_sum  = (idx_reg < cnt_sm) && (32'(idx_reg) < 32'(depth_reg));
    assign out_free    = !mval_reg || m_tready;
    assign acc_sum     = {1'b0, acc_reg} + (SUM_W+1)'(rd_vol);
    assign tot         = {1'b0, bs_reg} + {1'b0, as_reg};
    assign diff        = (bs_reg >= as_reg) ? {1'b0, bs_reg - as_reg} : {1'b0, as_reg - bs_reg};
    assign mid_full    = SUM_W'(bb_reg) + SUM_W'(ba_reg);

    assign raddr = {rd_side, wrap(rd_side ? ahead_reg : bhead_reg, rd_idx)};
    assign waddr = {wr_side, wrap(wr_side ? ahead_reg : bhead_reg, wr_idx)};

    lbt_mem #(.AW(AW + 1)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    lbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (diff),
        .den   (tot),
        .done  (div_done),
        .quo   (quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                begin
                    state_next = (s_tuser[1:0] == REQ_CLEAR || s_tuser[1:0] == REQ_NONE)
                                 ? S_TB_RD : S_SRCH_RD;
                end
            S_SRCH_RD:  state_next = (idx_reg < cnt_sd) ? S_SRCH_CHK : S_ACT;
            S_SRCH_CHK: state_next = ranks_ahead ? S_SRCH_RD : S_ACT;
            S_ACT:
                if (rt_reg == REQ_QUERY)
                begin
                    state_next = S_TB_RD;
                end
                else if (qt_reg == '0)
                begin
                    state_next = found_reg ? S_DEL_RD : S_TB_RD;
                end
                else if (found_reg || cnt_sd == CW'(LEVELS))
                begin
                    state_next = S_REP0;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            S_DEL_RD:   state_next = (idx_reg < cnt_sd) ? S_DEL_WR : S_TB_RD;
            S_DEL_WR:   state_next = S_DEL_RD;
            S_INS_RD:   state_next = (idx_reg > pos_reg) ? S_INS_WR : S_REP0;
            S_INS_WR:   state_next = S_INS_RD;
            S_REP0:     state_next = (bcnt_reg != '0 && acnt_reg != '0) ? S_REP1 : S_TB_RD;
            S_REP1:     state_next = S_REP2;
            S_REP2:     state_next = (rd_price > ref_reg) ? S_RB_RD : S_TB_RD;
            S_RB_RD:    state_next = (idx_reg < bcnt_reg) ? S_RB_CHK : S_TB_RD;
            S_RB_CHK:   state_next = (rd_price > ref_reg) ? S_RB_RD : S_RA_RD;
            S_RA_RD:    state_next = (idx_reg < acnt_reg) ? S_RA_CHK : S_TB_RD;
            S_RA_CHK:   state_next = (rd_price < ref_reg) ? S_RA_RD : S_TB_RD;
            S_TB_RD:    state_next = S_TA_RD;
            S_TA_RD:    state_next = S_TA_CAP;
            S_TA_CAP:   state_next = S_SUM_RD;
            S_SUM_RD:
                if (idx_lt_sum)
                begin
                    state_next = S_SUM_ACC;
                end
                else if (sm_reg)
                begin
                    state_next = S_DIV;
                end
            S_SUM_ACC:  state_next = S_SUM_RD;
            S_DIV:      state_next = (tot == '0) ? S_OUT : S_DIV_WAIT;
            S_DIV_WAIT: state_next = div_done ? S_OUT : S_DIV_WAIT;
            S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        rt_next = rt_reg;     sd_next = sd_reg;       sm_next = sm_reg;
        pr_next = pr_reg;     qt_next = qt_reg;       ref_next = ref_reg;
        bb_next = bb_reg;     ba_next = ba_reg;       fv_next = fv_reg;
        lvl_next = lvl_reg;   idx_next = idx_reg;     pos_next = pos_reg;
        bcnt_next = bcnt_reg; acnt_next = acnt_reg;
        bhead_next = bhead_reg; ahead_next = ahead_reg;
        found_next = found_reg; crossed_next = crossed_reg; full_next = full_reg;
        acc_next = acc_reg;   bs_next = bs_reg;       as_next = as_reg;
        imb_next = imb_reg;
        mdat_next = mdat_reg;
        mval_next = (mval_reg && m_tready) ? 1'b0 : mval_reg;
        rd_side = SIDE_BID;   rd_idx = '0;
        wr_side = sd_reg;     wr_idx = '0;
        we = 1'b0;            wdata = rdata;
        div_start = 1'b0;

        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                begin
                    rt_next      = s_tuser[1:0];
                    sd_next      = s_tuser[2];
                    pr_next      = s_tdata[PRICE_W-1:0];
                    qt_next      = s_tdata[ENTRY_W-1:PRICE_W];
                    idx_next     = '0;
                    crossed_next = 1'b0;
                    full_next    = 1'b0;
                    lvl_next     = '0;
                    if (s_tuser[1:0] == REQ_CLEAR)
                    begin
                        bcnt_next = '0;
                        acnt_next = '0;
                    end
                end
            S_SRCH_RD:
            begin
                rd_side = sd_reg;
                rd_idx  = idx_reg;
                if (!(idx_reg < cnt_sd))
                begin
                    pos_next   = idx_reg;
                    found_next = 1'b0;
                end
            end
            S_SRCH_CHK:
                if (ranks_ahead)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    pos_next   = idx_reg;
                    found_next = (rd_price == pr_reg);
                    fv_next    = rd_vol;
                end
            S_ACT:
                if (rt_reg == REQ_QUERY)
                begin
                    lvl_next = found_reg ? fv_reg : '0;
                end
                else if (qt_reg == '0)
                begin
                    idx_next = pos_reg + CW'(1);
                end
                else if (found_reg)
                begin
                    we     = 1'b1;
                    wr_idx = pos_reg;
                    wdata  = {qt_reg, pr_reg};
                end
                else if (cnt_sd == CW'(LEVELS))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    idx_next = cnt_sd;
                end
            S_DEL_RD:
            begin
                rd_side = sd_reg;
                rd_idx  = idx_reg;
                if (!(idx_reg < cnt_sd))
                begin
                    if (sd_reg)
                        acnt_next = acnt_reg - CW'(1);
                    else
                        bcnt_next = bcnt_reg - CW'(1);
                end
            end
            S_DEL_WR:
            begin
                we       = 1'b1;
                wr_idx   = idx_reg - CW'(1);
                idx_next = idx_reg + CW'(1);
            end
            S_INS_RD:
            begin
                rd_side = sd_reg;
                rd_idx  = idx_reg - CW'(1);
                if (!(idx_reg > pos_reg))
                begin
                    we     = 1'b1;
                    wr_idx = pos_reg;
                    wdata  = {qt_reg, pr_reg};
                    if (sd_reg)
                        acnt_next = acnt_reg + CW'(1);
                    else
                        bcnt_next = bcnt_reg + CW'(1);
                end
            end
            S_INS_WR:
            begin
                we       = 1'b1;
                wr_idx   = idx_reg;
                idx_next = idx_reg - CW'(1);
            end
            S_REP0:
                rd_side = SIDE_ASK;
            S_REP1:
            begin
                rd_side  = SIDE_BID;
                ref_next = rd_price;
            end
            S_REP2:
                if (rd_price > ref_reg)
                begin
                    crossed_next = 1'b1;
                    idx_next     = '0;
                end
            S_RB_RD:
            begin
                rd_side = SIDE_BID;
                rd_idx  = idx_reg;
                if (!(idx_reg < bcnt_reg))
                begin
                    bhead_next = wrap(bhead_reg, idx_reg);
                    bcnt_next  = '0;
                end
            end
            S_RB_CHK:
                if (rd_price > ref_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    bhead_next = wrap(bhead_reg, idx_reg);
                    bcnt_next  = bcnt_reg - idx_reg;
                    ref_next   = rd_price;
                    idx_next   = '0;
                end
            S_RA_RD:
            begin
                rd_side = SIDE_ASK;
                rd_idx  = idx_reg;
                if (!(idx_reg < acnt_reg))
                begin
                    ahead_next = wrap(ahead_reg, idx_reg);
                    acnt_next  = '0;
                end
            end
            S_RA_CHK:
                if (rd_price < ref_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    ahead_next = wrap(ahead_reg, idx_reg);
                    acnt_next  = acnt_reg - idx_reg;
                end
            S_TB_RD:
            begin
                rd_side  = SIDE_BID;
                idx_next = '0;
                sm_next  = SIDE_BID;
                acc_next = '0;
            end
            S_TA_RD:
            begin
                rd_side = SIDE_ASK;
                bb_next = (bcnt_reg != '0) ? rd_price : '0;
            end
            S_TA_CAP:
                ba_next = (acnt_reg != '0) ? rd_price : '0;
            S_SUM_RD:
            begin
                rd_side = sm_reg;
                rd_idx  = idx_reg;
                if (!idx_lt_sum)
                begin
                    if (sm_reg)
                    begin
                        as_next = acc_reg;
                    end
                    else
                    begin
                        bs_next  = acc_reg;
                        sm_next  = SIDE_ASK;
                        idx_next = '0;
                        acc_next = '0;
                    end
                end
            end
            S_SUM_ACC:
            begin
                acc_next = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
                idx_next = idx_reg + CW'(1);
            end
            S_DIV:
                if (tot == '0)
                begin
                    imb_next = '0;
                end
                else
                begin
                    div_start = 1'b1;
                end
            S_DIV_WAIT:
                if (div_done)
                begin
                    if (bs_reg >= as_reg)
                        imb_next = quo[IMB_W-1] ? {1'b0, {(IMB_W-1){1'b1}}} : quo;
                    else
                        imb_next = IMB_W'(-quo);
                end
            S_OUT:
                if (out_free)
                begin
                    mval_next = 1'b1;
                    mdat_next = {7'b0, full_reg, crossed_reg, lvl_reg, imb_reg, as_reg, bs_reg,
                        (bcnt_reg != '0 && acnt_reg != '0) ? MID_W'(mid_full) : MID_W'(0),
                        (bcnt_reg != '0 && acnt_reg != '0 && ba_reg >= bb_reg)
                            ? PRICE_W'(ba_reg - bb_reg) : PRICE_W'(0),
                        acnt_reg != '0, ba_reg, bcnt_reg != '0, bb_reg};
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bcnt_reg  <= '0;
            acnt_reg  <= '0;
            bhead_reg <= '0;
            ahead_reg <= '0;
            mval_reg  <= 1'b0;
            depth_reg <= DEPTH_RST;
        end
        else
        begin
            state_reg <= state_next;
            bcnt_reg  <= bcnt_next;
            acnt_reg  <= acnt_next;
            bhead_reg <= bhead_next;
            ahead_reg <= ahead_next;
            mval_reg  <= mval_next;
            if (psel && penable && pwrite && paddr[2] == REG_DEPTH)
            begin
                depth_reg <= pwdata[DEPTH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rt_reg <= rt_next;   sd_reg <= sd_next;   sm_reg <= sm_next;
        pr_reg <= pr_next;   qt_reg <= qt_next;   ref_reg <= ref_next;
        bb_reg <= bb_next;   ba_reg <= ba_next;   fv_reg <= fv_next;
        lvl_reg <= lvl_next; idx_reg <= idx_next; pos_reg <= pos_next;
        found_reg <= found_next; crossed_reg <= crossed_next; full_reg <= full_next;
        acc_reg <= acc_next; bs_reg <= bs_next;   as_reg <= as_next;
        imb_reg <= imb_next; mdat_reg <= mdat_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdat_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_DEPTH) ? PDATA_W'(depth_reg) : '0;

endmodule

### sv/lbt_chk.sv
// Port-level checks for the L2 order book level table, bound to the top level.
// Depends on lbt_pkg and l2_order_book_level_table.
module lbt_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lbt_pkg::M_TDATA_W-1:0] m_tdata
);
    import lbt_pkg::*;

    // one transaction in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_bid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[24] |-> m_tdata[23:0] == '0)
        else $error("best bid nonzero on empty side");

    a_one_sided: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !(m_tdata[24] && m_tdata[49]) |-> m_tdata[98:50] == '0)
        else $error("spread or mid on one-sided book");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

endmodule

bind l2_order_book_level_table lbt_chk u_lbt_chk (.*);
